// ===== design/audio_segment_crossfade_splicer_macros.svh =====
// Assertion macros for the crossfade splicer RTL.
// Needs a clk and an active-low rst_n in the scope that uses them.
`ifndef AUDIO_SEGMENT_CROSSFADE_SPLICER_MACROS_SVH
`define AUDIO_SEGMENT_CROSSFADE_SPLICER_MACROS_SVH

// Checked only outside reset.
`define ASC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASC_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/asc_pkg.sv =====
// Shared constants and types of the crossfade splicer.
// No dependencies.
package asc_pkg;
  localparam int MAX_FADE_FRAMES = 16384;
  localparam int MAX_CHANNELS    = 2;
  localparam int HOLD_DEPTH      = MAX_FADE_FRAMES * MAX_CHANNELS;
  localparam int HOLD_AW         = $clog2(HOLD_DEPTH);
  localparam int CNT_W           = HOLD_AW + 1;
  localparam int FADE_W          = 15;
  localparam int CHAN_W          = 2;
  localparam int SAMPLE_W        = 16;
  localparam int FRAMES_W        = 24;
  localparam int SIS_W           = 25;
  localparam int WS_W            = 17;
  localparam int CFG_W           = 15;

  localparam logic CFG_FADE     = 1'b0;
  localparam logic CFG_CHANNELS = 1'b1;

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef struct packed {
    logic                       action;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first;
    logic [FRAMES_W-1:0]        frames;
  } cmd_t;

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } emit_t;
endpackage

// ===== design/audio_segment_crossfade_splicer.sv =====
// Top level of the linear crossfade audio splicer.
// Depends on asc_pkg, asc_front, asc_div, asc_back, asc_ram.
//
// Queue-style ports on both sides. A drain goes through DRAIN_OUT, a plain push
// through PUSH and, with the held tail at capacity, APP_OUT, and a mixing push
// through MIX_RD, MIX_MUL and MIX_WR, set by the back end's read-modify-write
// of the single hold RAM. A segment's first sample also waits in DIV for the bit-serial weight-step divider.
// A two-entry command queue and a two-entry result queue decouple the ports
// from the back end. Configuration may be written only while idle; there is
// no clearing pass after reset.
module audio_segment_crossfade_splicer import asc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic                       in_action,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic                       in_segment_first,
  input  logic [FRAMES_W-1:0]        in_segment_frames,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_drain_last,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata
);
  logic [FADE_W-1:0]   fade_r;
  logic [CHAN_W-1:0]   chan_r;
  logic                cmd_valid, cmd_take, oq_full;
  cmd_t                cmd;
  emit_t               emit;
  logic                div_start, div_done;
  logic [FADE_W-1:0]   div_divisor;
  logic [WS_W-1:0]     div_quot;
  logic                ram_we, ram_re;
  logic [HOLD_AW-1:0]  ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

  emit_t      oq_r [2];
  logic       oq_wp_r, oq_rp_r;
  logic [1:0] oq_cnt_r;
  logic       oq_wr, oq_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_r <= '0;
      chan_r <= CHAN_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FADE:     fade_r <= cfg_wdata[FADE_W-1:0];
        CFG_CHANNELS: chan_r <= cfg_wdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  asc_front u_front (
    .clk, .rst_n, .push, .full, .in_action, .in_sample_in, .in_segment_first,
    .in_segment_frames, .cmd_valid, .cmd, .cmd_take
  );

  asc_div u_div (
    .clk, .rst_n, .start(div_start), .divisor(div_divisor), .done(div_done),
    .quotient(div_quot)
  );

  asc_ram #(.WIDTH(SAMPLE_W), .DEPTH(HOLD_DEPTH)) u_hold (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata), .re(ram_re),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  asc_back u_back (
    .clk, .rst_n, .fade_r, .chan_r, .cmd_valid, .cmd, .cmd_take, .oq_full, .emit,
    .div_start, .div_divisor, .div_done, .div_quot, .ram_we, .ram_waddr,
    .ram_wdata, .ram_re, .ram_raddr, .ram_rdata
  );

  // result queue
  assign oq_full        = oq_cnt_r[1];
  assign empty          = oq_cnt_r == 2'd0;
  assign oq_wr          = emit.valid && !oq_full;
  assign oq_rd          = pop && !empty;
  assign out_sample_out = oq_r[oq_rp_r].sample;
  assign out_drain_last = oq_r[oq_rp_r].last;

  always_ff @(posedge clk) begin
    if (oq_wr) begin
      oq_r[oq_wp_r] <= emit;
    end
    if (!rst_n) begin
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (oq_wr) oq_wp_r <= ~oq_wp_r;
      if (oq_rd) oq_rp_r <= ~oq_rp_r;
      oq_cnt_r <= oq_cnt_r + {1'b0, oq_wr} - {1'b0, oq_rd};
    end
  end
endmodule

// ===== design/asc_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No dependencies.
module asc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== design/asc_front.sv =====
// Input side: accepts transactions and queues decoded commands for the back end.
// Depends on asc_pkg.
module asc_front import asc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic                       in_action,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic                       in_segment_first,
  input  logic [FRAMES_W-1:0]        in_segment_frames,
  output logic                       cmd_valid,
  output cmd_t                       cmd,
  input  logic                       cmd_take
);
  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign full      = cnt_r[1];
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd       = q_r[rp_r];
  assign wr        = push && !full;
  assign rd        = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= '{action: in_action, sample: in_sample_in,
                     first: in_segment_first, frames: in_segment_frames};
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

// ===== design/asc_div.sv =====
// Restoring divider for the per-segment weight step, 65536 / divisor.
// One quotient bit per cycle. Depends on asc_pkg.
module asc_div import asc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [FADE_W-1:0] divisor,
  output logic              done,
  output logic [WS_W-1:0]   quotient
);
  logic [WS_W-1:0]   dq_r;
  logic [FADE_W:0]   rem_r;
  logic [FADE_W-1:0] dv_r;
  logic [4:0]        cnt_r;
  logic              busy_r;
  logic [FADE_W+1:0] rem_sh;
  logic              ge;

  assign rem_sh   = {rem_r, dq_r[WS_W-1]};
  assign ge       = rem_sh >= {2'b0, dv_r};
  assign quotient = dq_r;
  assign done     = busy_r && cnt_r == 5'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'(WS_W);
      dq_r   <= WS_W'(1) << (WS_W - 1);
      rem_r  <= '0;
      dv_r   <= divisor;
    end else if (busy_r) begin
      if (cnt_r == 5'd0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 5'd1;
        rem_r <= ge ? (FADE_W+1)'(rem_sh - {2'b0, dv_r}) : rem_sh[FADE_W:0];
        dq_r  <= {dq_r[WS_W-2:0], ge};
      end
    end
  end
endmodule

// ===== design/asc_back.sv =====
// Back end: hold buffer bookkeeping, overlap mixing, append and drain.
// Depends on asc_pkg, asc_div (via top), the hold RAM and the macros header.
`include "audio_segment_crossfade_splicer_macros.svh"
module asc_back import asc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [FADE_W-1:0]          fade_r,
  input  logic [CHAN_W-1:0]          chan_r,
  input  logic                       cmd_valid,
  input  cmd_t                       cmd,
  output logic                       cmd_take,
  input  logic                       oq_full,
  output emit_t                      emit,
  output logic                       div_start,
  output logic [FADE_W-1:0]          div_divisor,
  input  logic                       div_done,
  input  logic [WS_W-1:0]            div_quot,
  output logic                       ram_we,
  output logic [HOLD_AW-1:0]         ram_waddr,
  output logic [SAMPLE_W-1:0]        ram_wdata,
  output logic                       ram_re,
  output logic [HOLD_AW-1:0]         ram_raddr,
  input  logic [SAMPLE_W-1:0]        ram_rdata
);
  typedef enum logic [2:0] {
    S_IDLE, S_DRAIN_OUT, S_DIV, S_PUSH, S_MIX_RD, S_MIX_MUL, S_MIX_WR, S_APP_OUT
  } state_t;

  localparam logic [FADE_W-1:0] FADE_MAX = FADE_W'(MAX_FADE_FRAMES);

  state_t                     state_r;
  cmd_t                       cur_r;
  logic [CNT_W-1:0]           count_r;
  logic [HOLD_AW-1:0]         rp_r, pos_r;
  logic [FADE_W-1:0]          ov_r, fr1_r;
  logic [SIS_W-1:0]           sis_r;
  logic [WS_W-1:0]            ws_r;
  logic signed [SAMPLE_W-1:0] old_r;
  logic [15:0]                w_r;
  logic signed [33:0]         p1_r, p2_r;

  logic                       sh;
  logic [FADE_W-1:0]          fade_eff, ov_calc, frame1;
  logic [CNT_W-1:0]           held, m1, ov_samples, back, cap;
  logic                       in_ov, take;
  logic [HOLD_AW-1:0]         pos_calc, wr_pos;
  logic [31:0]                wprod;
  logic [15:0]                w_calc;
  logic signed [33:0]         p1_calc, p2_calc;
  logic signed [34:0]         sum;
  logic signed [18:0]         mixed;
  logic [SAMPLE_W-1:0]        mix_sat;
  logic [SIS_W-1:0]           sis_inc;

  // channel_count 0 and 1 are mono, 2 and 3 stereo
  assign sh       = chan_r[1];
  assign fade_eff = (fade_r > FADE_MAX) ? FADE_MAX : fade_r;
  assign held     = sh ? {1'b0, count_r[CNT_W-1:1]} : count_r;
  assign m1       = ({1'b0, fade_eff} < held) ? {1'b0, fade_eff} : held;
  assign ov_calc  = ({8'b0, m1} < cmd.frames) ? m1[FADE_W-1:0] : cmd.frames[FADE_W-1:0];

  assign ov_samples = sh ? {ov_r, 1'b0} : {1'b0, ov_r};
  assign cap        = sh ? {fade_eff, 1'b0} : {1'b0, fade_eff};
  assign in_ov      = sis_r < {{(SIS_W-CNT_W){1'b0}}, ov_samples};
  assign back       = ov_samples - sis_r[CNT_W-1:0];
  assign pos_calc   = HOLD_AW'(rp_r + count_r[HOLD_AW-1:0] - back[HOLD_AW-1:0]);
  assign wr_pos     = HOLD_AW'(rp_r + count_r[HOLD_AW-1:0]);
  assign frame1     = (sh ? {1'b0, sis_r[FADE_W-1:1]} : sis_r[FADE_W-1:0]) + 1'b1;
  assign sis_inc    = (sis_r == '1) ? sis_r : sis_r + 1'b1;

  assign wprod  = fr1_r * ws_r;
  assign w_calc = (wprod > 32'd65535) ? 16'hFFFF : wprod[15:0];

  assign p1_calc = old_r * $signed({1'b0, 17'(17'h10000 - {1'b0, w_r})});
  assign p2_calc = cur_r.sample * $signed({1'b0, w_r});
  // floor((x + half) / 2^16), convex mix keeps it in range
  assign sum     = 35'(p1_r) + 35'(p2_r) + 35'sd32768;
  assign mixed   = 19'(sum >>> 16);
  assign mix_sat = (mixed > 19'sd32767) ? 16'h7FFF :
                   (mixed < -19'sd32768) ? 16'h8000 : mixed[15:0];

  assign take        = state_r == S_IDLE && cmd_valid && !oq_full;
  assign cmd_take    = take;
  assign div_start   = take && cmd.action == ACT_PUSH && cmd.first;
  assign div_divisor = ov_calc + 1'b1;

  always_comb begin
    ram_re      = 1'b0;
    ram_raddr   = rp_r;
    ram_we      = 1'b0;
    ram_waddr   = wr_pos;
    ram_wdata   = cur_r.sample;
    emit        = '{valid: 1'b0, sample: ram_rdata, last: 1'b0};
    case (state_r)
      S_IDLE: begin
        ram_re = take && cmd.action == ACT_DRAIN && count_r != '0;
      end
      S_DRAIN_OUT: begin
        emit.valid = 1'b1;
        emit.last  = count_r == CNT_W'(1);
      end
      S_PUSH: begin
        if (in_ov) begin
          ram_re    = back <= count_r;
          ram_raddr = pos_calc;
        end else if (count_r == '0 && cap == '0) begin
          emit.valid  = 1'b1;
          emit.sample = cur_r.sample;
        end else if (count_r >= cap || count_r[CNT_W-1]) begin
          ram_re = 1'b1;
        end else begin
          ram_we = 1'b1;
        end
      end
      S_MIX_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = mix_sat;
      end
      S_APP_OUT: begin
        // oldest goes out, new sample lands behind the newest held one
        emit.valid = 1'b1;
        ram_we     = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      rp_r    <= '0;
      ov_r    <= '0;
      sis_r   <= '0;
      ws_r    <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (take) begin
            cur_r <= cmd;
            if (cmd.action == ACT_DRAIN) begin
              state_r <= (count_r != '0) ? S_DRAIN_OUT : S_IDLE;
            end else if (cmd.first) begin
              ov_r    <= ov_calc;
              sis_r   <= '0;
              state_r <= S_DIV;
            end else begin
              state_r <= S_PUSH;
            end
          end
        end
        S_DRAIN_OUT: begin
          rp_r    <= rp_r + 1'b1;
          count_r <= count_r - 1'b1;
          state_r <= S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            ws_r    <= div_quot;
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          sis_r   <= sis_inc;
          state_r <= S_IDLE;
          if (in_ov) begin
            // tail already drained past this position: sample is dropped
            if (back <= count_r) begin
              pos_r   <= pos_calc;
              fr1_r   <= frame1;
              state_r <= S_MIX_RD;
            end
          end else if (count_r == '0 && cap == '0) begin
            state_r <= S_IDLE;
          end else if (count_r >= cap || count_r[CNT_W-1]) begin
            state_r <= S_APP_OUT;
          end else begin
            count_r <= count_r + 1'b1;
          end
        end
        S_MIX_RD: begin
          old_r   <= ram_rdata;
          w_r     <= w_calc;
          state_r <= S_MIX_MUL;
        end
        S_MIX_MUL: begin
          p1_r    <= p1_calc;
          p2_r    <= p2_calc;
          state_r <= S_MIX_WR;
        end
        S_MIX_WR: begin
          state_r <= S_IDLE;
        end
        S_APP_OUT: begin
          rp_r    <= rp_r + 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASC_CHECK(a_count_cap, count_r <= CNT_W'(HOLD_DEPTH), "hold count above capacity")
  `ASC_CHECK(a_emit_room, emit.valid |-> !oq_full, "emit into full output queue")
  `ASC_CHECK(a_div_state, div_done |-> state_r == S_DIV, "divider done outside DIV")
  `ASC_CHECK(a_no_rw_clash, ram_we |-> !ram_re, "hold RAM read and write together")
endmodule
